### hw/rtl/bst_pkg.sv
package bst_pkg;

  localparam int unsigned MaxDepth   = 64;
  localparam int unsigned DepthW     = 7;
  localparam int unsigned StackAw    = 6;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);

  typedef enum logic [2:0] {
    PH_EXPECT     = 3'd0,
    PH_INT_START  = 3'd1,
    PH_INT_DIGITS = 3'd2,
    PH_STR_LEN    = 3'd3,
    PH_STR_BODY   = 3'd4,
    PH_DONE       = 3'd5,
    PH_ERROR      = 3'd6,
    PH_ENDED      = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    K_INT     = 3'd0,
    K_STR_HDR = 3'd1,
    K_STR_BYT = 3'd2,
    K_LIST    = 3'd3,
    K_DICT    = 3'd4,
    K_CLOSE   = 3'd5,
    K_ERROR   = 3'd6,
    K_END     = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    E_NONE       = 4'd0,
    E_END_VALUE  = 4'd1,
    E_BAD_BYTE   = 4'd2,
    E_TOO_DEEP   = 4'd3,
    E_INT_RANGE  = 4'd4,
    E_INT_UNTERM = 4'd5,
    E_INT_CHAR   = 4'd6,
    E_INT_EMPTY  = 4'd7,
    E_LEN_LONG   = 4'd8,
    E_LEN_UNTERM = 4'd9,
    E_NO_COLON   = 4'd10,
    E_STR_SHORT  = 4'd11,
    E_LIST_OPEN  = 4'd12,
    E_DICT_OPEN  = 4'd13,
    E_KEY_TYPE   = 4'd14
  } err_e;

  // classified input item
  typedef struct packed {
    logic       is_end;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] data;
  } cls_t;

  // result item, fields from the token format
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] number;
    logic [7:0]  payload_byte;
    logic        string_last;
    logic        is_key;
    logic [6:0]  level;
    logic [31:0] offset;
    logic [3:0]  error_code;
    logic        leading_zero_warn;
    logic        negative_zero_warn;
    logic        ok;
  } tok_t;

endpackage

### hw/rtl/bencode_stream_tokenizer.sv
// channel    | group                | contents
// input      | s_axis_*             | tdata: in_byte; tuser: op
// result     | m_axis_*             | tdata/tuser/tlast: token fields
// config     | cfg_we_i/cfg_wdata_i | max_depth
// one byte per cycle sustained unless the output stalls; per-byte work is one
// multiply-add by ten and one read of the container stack, done in the back end.
// a two-entry queue parts classification from execution; the result register
// frees as it is taken, so a stalled output holds the input back after two.
// reset clears all control state; the stack memory needs no clearing.
module bencode_stream_tokenizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // in_byte
  input  logic         s_axis_tuser_i,   // op
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // number[63:0], payload_byte[71:64], level[78:72], offset[110:79],
  // error_code[114:111], zero pad
  output logic [119:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,   // string_last
  // kind[2:0], is_key[3], leading_zero_warn[4], negative_zero_warn[5], ok[6]
  output logic [6:0]   m_axis_tuser_o
);

  logic [6:0]    max_depth_q;
  logic          qv, qr;
  bst_pkg::cls_t qd;
  bst_pkg::tok_t t;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_depth_q <= 7'(bst_pkg::MaxDepth);
    else if (cfg_we_i) max_depth_q <= cfg_wdata_i;
  end

  bst_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_data_i({s_axis_tdata_i, s_axis_tuser_i}),
    .q_valid_o(qv), .q_ready_i(qr), .q_data_o(qd)
  );

  bst_back u_back (
    .clk_i, .rst_ni, .max_depth_i(max_depth_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_data_i(qd),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .out_data_o(t)
  );

  assign m_axis_tdata_o = {5'd0, t.error_code, t.offset, t.level, t.payload_byte, t.number};
  assign m_axis_tlast_o = t.string_last;
  assign m_axis_tuser_o = {t.ok, t.negative_zero_warn, t.leading_zero_warn, t.is_key, t.kind};

endmodule

### hw/rtl/bst_front.sv
module bst_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [8:0]    in_data_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output bst_pkg::cls_t q_data_o
);

  bst_pkg::cls_t              mem_q [bst_pkg::QDepth];
  logic [bst_pkg::QPtrW-1:0]  wr_q, rd_q;
  logic [bst_pkg::QPtrW:0]    cnt_q;
  bst_pkg::cls_t              cls;
  logic                       push, pop;

  // classify the byte
  always_comb begin
    cls.is_end   = in_data_i[0];
    cls.data     = in_data_i[8:1];
    cls.is_digit = (in_data_i[8:1] >= 8'h30) && (in_data_i[8:1] <= 8'h39);
    cls.digit    = in_data_i[4:1];
  end

  assign in_ready_o = (cnt_q != (bst_pkg::QPtrW+1)'(bst_pkg::QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = mem_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (bst_pkg::QPtrW+1)'(push) - (bst_pkg::QPtrW+1)'(pop);
    end
  end

endmodule

### hw/rtl/bst_back.sv
module bst_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [6:0]    max_depth_i,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  bst_pkg::cls_t q_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bst_pkg::tok_t out_data_o
);

  bst_pkg::phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [6:0]  depth_q, depth_d;
  logic [63:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic        fz_q, fz_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] start_q, start_d;
  logic        key_q, key_d;
  logic [3:0]  ferr_q, ferr_d;
  logic [31:0] eoff_q, eoff_d;
  logic [31:0] trail_q, trail_d;
  // top of stack kept in flops; rest in memory
  logic [1:0]  top_q, top_d;
  logic [1:0]  stk_q [bst_pkg::MaxDepth];
  logic        push, pop, vflip;
  // entry under the top, read ahead from the memory
  logic [1:0]  below_q;

  logic        outv_q;
  bst_pkg::tok_t out_q, tok;
  logic        emit, take;

  logic [67:0] mul10;
  logic [64:0] sum;
  logic [6:0]  limit;
  logic        nested, want_key;
  logic [3:0]  ecode;
  logic [31:0] eat;

  function automatic logic [bst_pkg::StackAw-1:0] StackIdx(input logic [6:0] v);
    StackIdx = v[bst_pkg::StackAw-1:0];
  endfunction

  assign q_ready_o   = !outv_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  // times ten as two shifted adds
  assign mul10 = {1'b0, mag_q, 3'd0} + {3'd0, mag_q, 1'b0};
  assign sum   = {1'b0, mul10[63:0]} + {61'd0, q_data_i.digit};
  assign limit = (max_depth_i > 7'(bst_pkg::MaxDepth)) ? 7'(bst_pkg::MaxDepth) : max_depth_i;
  assign nested   = depth_q != '0;
  assign want_key = nested && top_q[0] && !top_q[1];

  // next state and token
  always_comb begin
    phase_d = phase_q; pos_d = pos_q; depth_d = depth_q; mag_d = mag_q;
    neg_d = neg_q; dcnt_d = dcnt_q; fz_d = fz_q; rem_d = rem_q;
    start_d = start_q; key_d = key_q; ferr_d = ferr_q; eoff_d = eoff_q;
    trail_d = trail_q; top_d = top_q;
    push = 1'b0; pop = 1'b0; vflip = 1'b0;
    emit = 1'b0; tok = '0; ecode = bst_pkg::E_NONE; eat = pos_q;
    if (q_data_i.is_end) begin
      if (phase_q != bst_pkg::PH_ENDED && phase_q != bst_pkg::PH_DONE &&
          phase_q != bst_pkg::PH_ERROR) begin
        ecode = bst_pkg::E_END_VALUE;
        unique case (phase_q)
          bst_pkg::PH_EXPECT: begin
            if (nested) begin
              if (!top_q[0]) ecode = bst_pkg::E_LIST_OPEN;
              else if (!top_q[1]) ecode = bst_pkg::E_DICT_OPEN;
            end
          end
          bst_pkg::PH_INT_START, bst_pkg::PH_INT_DIGITS: ecode = bst_pkg::E_INT_UNTERM;
          bst_pkg::PH_STR_LEN: ecode = bst_pkg::E_LEN_UNTERM;
          default: begin
            ecode = bst_pkg::E_STR_SHORT;
            eat   = start_q;
          end
        endcase
        if (ferr_q == bst_pkg::E_NONE) begin
          ferr_d = ecode;
          eoff_d = eat;
        end
      end
      phase_d = bst_pkg::PH_ENDED;
      emit = 1'b1;
      tok.kind = bst_pkg::K_END;
      tok.error_code = ferr_d;
      tok.ok = (ferr_d == bst_pkg::E_NONE);
      tok.offset = tok.ok ? pos_q : eoff_d;
      tok.number = tok.ok ? {32'd0, trail_q} : '0;
    end else if (phase_q != bst_pkg::PH_ENDED && phase_q != bst_pkg::PH_ERROR) begin
      pos_d = pos_q + 32'd1;
      tok.level = depth_q;
      tok.offset = pos_q;
      unique case (phase_q)
        bst_pkg::PH_DONE: begin
          if (trail_q != '1) trail_d = trail_q + 32'd1;
        end
        bst_pkg::PH_EXPECT: begin
          if (nested && (!top_q[0] || want_key) && q_data_i.data == "e") begin
            pop = 1'b1; depth_d = depth_q - 7'd1;
            emit = 1'b1; tok.kind = bst_pkg::K_CLOSE; tok.level = depth_d;
            top_d = below_q;
            if (depth_d == '0) phase_d = bst_pkg::PH_DONE;
            else if (below_q[0]) top_d[1] = ~below_q[1];
          end else if (want_key && !q_data_i.is_digit) begin
            ecode = bst_pkg::E_KEY_TYPE;
          end else if (q_data_i.is_digit) begin
            start_d = pos_q; mag_d = {60'd0, q_data_i.digit}; dcnt_d = 2'd1;
            fz_d = (q_data_i.digit == 4'd0); rem_d = 34'd1; key_d = want_key;
            phase_d = bst_pkg::PH_STR_LEN;
          end else if (q_data_i.data == "i") begin
            start_d = pos_q; mag_d = '0; neg_d = 1'b0; dcnt_d = '0; fz_d = 1'b0;
            phase_d = bst_pkg::PH_INT_START;
          end else if (q_data_i.data == "l" || q_data_i.data == "d") begin
            if (depth_q >= limit) begin
              ecode = bst_pkg::E_TOO_DEEP;
            end else begin
              emit = 1'b1;
              tok.kind = (q_data_i.data == "l") ? bst_pkg::K_LIST : bst_pkg::K_DICT;
              push = 1'b1; depth_d = depth_q + 7'd1;
              top_d = {1'b0, q_data_i.data == "d"};
            end
          end else begin
            ecode = bst_pkg::E_BAD_BYTE;
          end
        end
        bst_pkg::PH_INT_START, bst_pkg::PH_INT_DIGITS: begin
          phase_d = bst_pkg::PH_INT_DIGITS;
          if (phase_q == bst_pkg::PH_INT_START && q_data_i.data == "-") begin
            neg_d = 1'b1;
          end else if (q_data_i.is_digit) begin
            if (mul10[67:64] != '0 || sum[64]) begin
              ecode = bst_pkg::E_INT_RANGE;
            end else begin
              mag_d = sum[63:0];
              if (dcnt_q == 2'd0) fz_d = (q_data_i.digit == 4'd0);
              if (dcnt_q != 2'd2) dcnt_d = dcnt_q + 2'd1;
            end
          end else if (q_data_i.data != "e") begin
            ecode = bst_pkg::E_INT_CHAR;
          end else if (dcnt_q == 2'd0) begin
            ecode = bst_pkg::E_INT_EMPTY;
          end else if (mag_q[63] && (!neg_q || mag_q[62:0] != '0)) begin
            ecode = bst_pkg::E_INT_RANGE;
          end else begin
            emit = 1'b1; tok.kind = bst_pkg::K_INT; tok.offset = start_q;
            tok.number = neg_q ? (64'd0 - mag_q) : mag_q;
            tok.leading_zero_warn = (dcnt_q == 2'd2) && fz_q;
            tok.negative_zero_warn = neg_q && (mag_q == '0);
            vflip = 1'b1;
          end
        end
        bst_pkg::PH_STR_LEN: begin
          if (q_data_i.is_digit) begin
            if (rem_q >= 34'd10) begin
              ecode = bst_pkg::E_LEN_LONG;
            end else begin
              mag_d = sum[63:0]; rem_d = rem_q + 34'd1;
              if (dcnt_q != 2'd2) dcnt_d = dcnt_q + 2'd1;
            end
          end else if (q_data_i.data != ":") begin
            ecode = bst_pkg::E_NO_COLON;
          end else begin
            emit = 1'b1; tok.kind = bst_pkg::K_STR_HDR; tok.offset = start_q;
            tok.number = mag_q; tok.is_key = key_q;
            tok.leading_zero_warn = (dcnt_q == 2'd2) && fz_q;
            start_d = pos_d; rem_d = mag_q[33:0];
            if (mag_q == '0) vflip = 1'b1;
            else phase_d = bst_pkg::PH_STR_BODY;
          end
        end
        default: begin
          emit = 1'b1; tok.kind = bst_pkg::K_STR_BYT;
          tok.payload_byte = q_data_i.data; tok.is_key = key_q;
          rem_d = rem_q - 34'd1;
          if (rem_d == '0) begin
            tok.string_last = 1'b1; vflip = 1'b1;
          end
        end
      endcase
      // value finished
      if (vflip) begin
        if (!nested) phase_d = bst_pkg::PH_DONE;
        else begin
          phase_d = bst_pkg::PH_EXPECT;
          if (top_q[0]) top_d[1] = ~top_q[1];
        end
      end
      if (ecode != bst_pkg::E_NONE) begin
        push = 1'b0; pop = 1'b0;
        emit = 1'b1; phase_d = bst_pkg::PH_ERROR;
        if (ferr_q == bst_pkg::E_NONE) begin
          ferr_d = ecode; eoff_d = pos_q;
        end
        tok = '0; tok.kind = bst_pkg::K_ERROR; tok.level = depth_q;
        tok.offset = pos_q; tok.error_code = ecode;
        depth_d = depth_q; top_d = top_q; phase_d = bst_pkg::PH_ERROR;
      end
    end
  end

  // stack below the top entry, with the next-under entry read ahead
  always_ff @(posedge clk_i) begin
    if (take && push && nested) begin
      stk_q[StackIdx(depth_q - 7'd1)] <= top_q;
    end
    if (take && push) begin
      below_q <= top_q;
    end else if (take && pop) begin
      below_q <= stk_q[StackIdx(depth_q - 7'd3)];
    end
  end

  // control and token state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bst_pkg::PH_EXPECT; pos_q <= '0; depth_q <= '0; mag_q <= '0;
      neg_q <= 1'b0; dcnt_q <= '0; fz_q <= 1'b0; rem_q <= '0; start_q <= '0;
      key_q <= 1'b0; ferr_q <= '0; eoff_q <= '0; trail_q <= '0; top_q <= '0;
      outv_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; pos_q <= pos_d; depth_q <= depth_d; mag_q <= mag_d;
        neg_q <= neg_d; dcnt_q <= dcnt_d; fz_q <= fz_d; rem_q <= rem_d;
        start_q <= start_d; key_q <= key_d; ferr_q <= ferr_d; eoff_q <= eoff_d;
        trail_q <= trail_d; top_q <= top_d;
      end
      if (take) outv_q <= emit;
      else if (out_ready_i) outv_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (take && emit) out_q <= tok;
  end

endmodule

### hw/rtl/bst_checker.sv
module bst_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [119:0] m_axis_tdata_o,
  input logic         m_axis_tlast_o,
  input logic [6:0]   m_axis_tuser_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // only string bytes carry tlast
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[2:0] == 3'(bst_pkg::K_STR_BYT))
    else $error("tlast on non-byte token");

  // ok only on end tokens
  a_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[6] |-> m_axis_tuser_o[2:0] == 3'(bst_pkg::K_END))
    else $error("ok outside end token");

endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (
  .clk_i, .rst_ni, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
  .m_axis_tlast_o, .m_axis_tuser_o
);

### tb/testbench.sv
module testbench;
  import bst_pkg::*;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic       OP_BYTE  = 1'b0;
  localparam logic       OP_END   = 1'b1;
  localparam int         CYCLE_LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [6:0]   cfg_wdata = '0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [7:0]   s_data = '0;
  logic         s_user = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [119:0] m_data;
  logic         m_last;
  logic [6:0]   m_user;

  bencode_stream_tokenizer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tokenizer state as predicted
  phase_e      ph;
  logic [31:0] pos;
  int          depth;
  logic [1:0]  stk [MaxDepth];
  logic [63:0] mag;
  logic        neg;
  logic [1:0]  dcnt;
  logic        fzero;
  logic [33:0] srem;
  logic [31:0] tstart;
  logic        skey;
  err_e        ferr;
  logic [31:0] eoff;
  logic [31:0] trail;
  logic [6:0]  max_depth;

  tok_t expected_tokens [$];
  int   errors = 0;
  int   cycles = 0;
  int   bytes_sent = 0;
  bit   sender_idles = 1'b1;
  bit   recv_idles = 1'b1;
  bit   hold_req = 1'b0;

  function automatic tok_t tok(kind_e k, int lvl, logic [31:0] off);
    tok_t t;
    t = '0;
    t.kind = k;
    t.level = lvl[6:0];
    t.offset = off;
    return t;
  endfunction

  // appends a token to the expected list
  function automatic void queue_token(tok_t t);
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic void fail_at(err_e c, logic [31:0] at);
    tok_t t;
    if (ferr == E_NONE) begin
      ferr = c;
      eoff = at;
    end
    ph = PH_ERROR;
    t = tok(K_ERROR, depth, at);
    t.error_code = c;
    queue_token(t);
  endfunction

  function automatic void value_done();
    if (depth == 0) begin
      ph = PH_DONE;
      return;
    end
    if (stk[depth-1][0]) stk[depth-1][1] = ~stk[depth-1][1];
    ph = PH_EXPECT;
  endfunction

  // works out the token, if any, for one accepted transfer
  function automatic void predict_token(logic op, logic [7:0] b);
    tok_t        t;
    logic        isd;
    logic [63:0] d;
    logic [31:0] p;
    logic [1:0]  top;
    logic        nested, want_key;
    int          lim;
    err_e        code;
    logic [31:0] at;
    isd = (b >= CH_0) && (b <= CH_9);
    d = {60'd0, 4'(b - CH_0)};
    if (op) begin
      if (ph != PH_ENDED && ph != PH_DONE && ph != PH_ERROR) begin
        code = E_END_VALUE;
        at = pos;
        if (ph == PH_EXPECT) begin
          if (depth > 0) begin
            top = stk[depth-1];
            if (!top[0]) code = E_LIST_OPEN;
            else if (!top[1]) code = E_DICT_OPEN;
          end
        end else if (ph == PH_INT_START || ph == PH_INT_DIGITS) begin
          code = E_INT_UNTERM;
        end else if (ph == PH_STR_LEN) begin
          code = E_LEN_UNTERM;
        end else begin
          code = E_STR_SHORT;
          at = tstart;
        end
        if (ferr == E_NONE) begin
          ferr = code;
          eoff = at;
        end
      end
      ph = PH_ENDED;
      t = tok(K_END, 0, (ferr != E_NONE) ? eoff : pos);
      t.error_code = ferr;
      t.ok = (ferr == E_NONE);
      t.number = (ferr == E_NONE) ? {32'd0, trail} : 64'd0;
      queue_token(t);
      return;
    end
    if (ph == PH_ENDED || ph == PH_ERROR) return;
    p = pos;
    pos = pos + 1;
    case (ph)
      PH_DONE: begin
        if (trail != '1) trail = trail + 1;
      end
      PH_EXPECT: begin
        nested = depth > 0;
        top = nested ? stk[depth-1] : 2'b00;
        want_key = nested && top[0] && !top[1];
        if (nested && (!top[0] || want_key) && b == CH_E) begin
          depth = depth - 1;
          queue_token(tok(K_CLOSE, depth, p));
          value_done();
        end else if (want_key && !isd) begin
          fail_at(E_KEY_TYPE, p);
        end else if (isd) begin
          tstart = p;
          mag = d;
          dcnt = 2'd1;
          fzero = (d == 0);
          srem = 34'd1;
          skey = want_key;
          ph = PH_STR_LEN;
        end else if (b == CH_I) begin
          tstart = p;
          mag = '0;
          neg = 1'b0;
          dcnt = '0;
          fzero = 1'b0;
          ph = PH_INT_START;
        end else if (b == CH_L || b == CH_D) begin
          lim = (max_depth > MaxDepth) ? MaxDepth : max_depth;
          if (depth >= lim) fail_at(E_TOO_DEEP, p);
          else begin
            queue_token(tok((b == CH_L) ? K_LIST : K_DICT, depth, p));
            stk[depth] = (b == CH_D) ? 2'b01 : 2'b00;
            depth = depth + 1;
          end
        end else begin
          fail_at(E_BAD_BYTE, p);
        end
      end
      PH_INT_START, PH_INT_DIGITS: begin
        if (ph == PH_INT_START && b == CH_MINUS) begin
          neg = 1'b1;
          ph = PH_INT_DIGITS;
        end else begin
          ph = PH_INT_DIGITS;
          if (isd) begin
            if (mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) fail_at(E_INT_RANGE, p);
            else begin
              mag = mag * 10 + d;
              if (dcnt == 0) fzero = (d == 0);
              if (dcnt < 2) dcnt = dcnt + 1;
            end
          end else if (b != CH_E) begin
            fail_at(E_INT_CHAR, p);
          end else if (dcnt == 0) begin
            fail_at(E_INT_EMPTY, p);
          end else if (mag > (neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)) begin
            fail_at(E_INT_RANGE, p);
          end else begin
            t = tok(K_INT, depth, tstart);
            t.number = neg ? -mag : mag;
            t.leading_zero_warn = (dcnt >= 2) && fzero;
            t.negative_zero_warn = neg && (mag == 0);
            queue_token(t);
            value_done();
          end
        end
      end
      PH_STR_LEN: begin
        if (isd) begin
          if (srem >= 10) fail_at(E_LEN_LONG, p);
          else begin
            mag = mag * 10 + d;
            srem = srem + 1;
            if (dcnt < 2) dcnt = dcnt + 1;
          end
        end else if (b != CH_COLON) begin
          fail_at(E_NO_COLON, p);
        end else begin
          t = tok(K_STR_HDR, depth, tstart);
          t.number = mag;
          t.is_key = skey;
          t.leading_zero_warn = (dcnt >= 2) && fzero;
          queue_token(t);
          tstart = pos;
          srem = mag[33:0];
          if (srem == 0) value_done();
          else ph = PH_STR_BODY;
        end
      end
      PH_STR_BODY: begin
        t = tok(K_STR_BYT, depth, p);
        t.payload_byte = b;
        t.is_key = skey;
        srem = srem - 1;
        if (srem == 0) begin
          t.string_last = 1'b1;
          value_done();
        end
        queue_token(t);
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch in %s: got %0h, expected %0h", what, got, exp);
    errors++;
  endtask

  // one transfer on the input side, with optional idle cycles before it
  task automatic send_item(logic op, logic [7:0] b);
    logic rdy;
    if (sender_idles && $urandom_range(99) < 35) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= op;
    do begin
      @(negedge clk_i);
      rdy = s_ready;
      @(posedge clk_i);
    end while (!rdy);
    bytes_sent++;
    predict_token(op, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  // waits for all tokens plus a margin for work that gives no token
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_max_depth(logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    max_depth = v;
  endtask

  task automatic gen_int();
    longint v;
    string  s;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: v = -longint'($urandom_range(0, 20));
      2: v = 64'h7FFF_FFFF_FFFF_FFFF;
      3: v = 64'h8000_0000_0000_0000;
      default: v = {$urandom, $urandom};
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(9) == 0) s = (v < 0) ? {"-0", s.substr(1, s.len() - 1)} : {"0", s};
    if ($urandom_range(19) == 0) s = "-0";
    send_text({"i", s, "e"});
  endtask

  task automatic gen_string();
    int    n;
    string pre;
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    pre = "";
    if ($urandom_range(7) == 0) pre = "0";
    send_text({pre, $sformatf("%0d:", n)});
    repeat (n) send_item(OP_BYTE, 8'($urandom));
  endtask

  task automatic gen_value(int lvl);
    int n;
    case ($urandom_range(0, (lvl >= 5) ? 1 : 3))
      0: gen_int();
      1: gen_string();
      2: begin
        send_item(OP_BYTE, CH_L);
        n = $urandom_range(0, 3);
        repeat (n) gen_value(lvl + 1);
        send_item(OP_BYTE, CH_E);
      end
      default: begin
        send_item(OP_BYTE, CH_D);
        n = $urandom_range(0, 3);
        repeat (n) begin
          gen_string();
          gen_value(lvl + 1);
        end
        send_item(OP_BYTE, CH_E);
      end
    endcase
  endtask

  // opens the top list and covers the integer and string corner cases
  task automatic test_directed();
    send_text("li-0ei007ei9223372036854775807ei-9223372036854775808e0:");
    send_text("02:");
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_text("d1:klee");
  endtask

  task automatic test_max_depth();
    wait_drained();
    write_max_depth(7'd0);
    send_text("i5e1:x");
    wait_drained();
    write_max_depth(7'd127);
    send_text("lldeee");
    wait_drained();
    write_max_depth(7'd2);
    send_text("le");
    wait_drained();
    write_max_depth(7'd64);
  endtask

  task automatic test_random();
    int start;
    bit held;
    start = bytes_sent;
    held = 1'b0;
    while (bytes_sent - start < 2000) begin
      if (bytes_sent - start >= 1000 && bytes_sent - start < 1400) begin
        sender_idles = 1'b0;
        recv_idles = 1'b0;
      end else begin
        sender_idles = 1'b1;
        recv_idles = 1'b1;
      end
      if (!held && bytes_sent - start > 500) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      gen_value(0);
    end
    sender_idles = 1'b1;
    recv_idles = 1'b1;
  endtask

  task automatic test_pause();
    wait_drained();
    gen_value(0);
  endtask

  // the stream ends cleanly or with one of the error cases
  task automatic test_ending();
    case ($urandom_range(0, 13))
      0: begin
        send_item(OP_BYTE, CH_E);
        repeat ($urandom_range(0, 5)) send_item(OP_BYTE, 8'($urandom));
      end
      1: send_item(OP_BYTE, 8'($urandom_range(8'h3B, 8'h60)));
      2: send_text("i99999999999999999999e");
      3: send_text("i9223372036854775808e");
      4: send_text("i12");
      5: send_text("12345678901:");
      6: send_text("3x");
      7: send_text("5:ab");
      8: send_text("di1e");
      9: begin
        wait_drained();
        write_max_depth(7'd1);
        send_item(OP_BYTE, CH_L);
      end
      10: send_text("ie");
      11: send_text("i1x");
      12: send_text("d");
      default: send_text("d1:k");
    endcase
    send_item(OP_END, 8'($urandom));
    send_item(OP_BYTE, 8'($urandom));
    send_item(OP_END, 8'($urandom));
  endtask

  // receiver side: random stalls and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        m_ready <= !recv_idles || ($urandom_range(99) >= 35);
      end
    end
  end

  // result checking, sampled mid-cycle ahead of the transfer edge
  always @(negedge clk_i) begin
    tok_t e;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_tokens.size() == 0) begin
        report("unexpected token kind", 64'(m_user[2:0]), 64'd0);
      end else begin
        e = expected_tokens.pop_front();
        if (m_user[2:0] != e.kind) report("kind", 64'(m_user[2:0]), 64'(e.kind));
        if (m_data[63:0] != e.number) report("number", m_data[63:0], e.number);
        if (m_data[71:64] != e.payload_byte)
          report("payload_byte", 64'(m_data[71:64]), 64'(e.payload_byte));
        if (m_last != e.string_last) report("string_last", 64'(m_last), 64'(e.string_last));
        if (m_user[3] != e.is_key) report("is_key", 64'(m_user[3]), 64'(e.is_key));
        if (m_data[78:72] != e.level) report("level", 64'(m_data[78:72]), 64'(e.level));
        if (m_data[110:79] != e.offset)
          report("offset", 64'(m_data[110:79]), 64'(e.offset));
        if (m_data[114:111] != e.error_code)
          report("error_code", 64'(m_data[114:111]), 64'(e.error_code));
        if (m_user[4] != e.leading_zero_warn)
          report("leading_zero_warn", 64'(m_user[4]), 64'(e.leading_zero_warn));
        if (m_user[5] != e.negative_zero_warn)
          report("negative_zero_warn", 64'(m_user[5]), 64'(e.negative_zero_warn));
        if (m_user[6] != e.ok) report("ok", 64'(m_user[6]), 64'(e.ok));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    ph = PH_EXPECT;
    pos = '0;
    depth = 0;
    foreach (stk[i]) stk[i] = 2'b00;
    mag = '0;
    neg = 1'b0;
    dcnt = '0;
    fzero = 1'b0;
    srem = '0;
    tstart = '0;
    skey = 1'b0;
    ferr = E_NONE;
    eoff = '0;
    trail = '0;
    max_depth = 7'd64;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_max_depth();
    test_random();
    test_pause();
    test_ending();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
